>>> rtl/core/uilst_pkg.sv
// Shared types and codes for the unique id list stack.
`default_nettype none
package uilst_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_ADD    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_PRESENT   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] node_id;
  } in_t;

  typedef struct packed {
    logic [15:0] result_id;
    status_t     status;
    logic [6:0]  entry_count;
  } out_t;

  // Strobes broadcast along the cell row.
  typedef struct packed {
    logic compare;
    logic append;
    logic shift;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/uilst_cell.sv
// One list slot: holds an id, compares it, loads or takes its right neighbor.
`default_nettype none
module uilst_cell #(
  parameter int ID_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire uilst_pkg::cell_cmd_t  cmd,
  input  wire logic                  sel_tail,
  input  wire logic                  sel_shift,
  input  wire logic [ID_WIDTH-1:0]   id,
  input  wire logic [ID_WIDTH-1:0]   right_entry,
  output logic      [ID_WIDTH-1:0]   entry,
  output logic                       match
);
  import uilst_pkg::*;

  logic [ID_WIDTH-1:0] entry_r;
  logic                match_r;

  always_ff @(posedge clk) begin
    if (cmd.append && sel_tail) begin
      entry_r <= id;
    end else if (cmd.shift && sel_shift) begin
      entry_r <= right_entry;
    end
    if (cmd.compare) begin
      match_r <= (entry_r == id);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

>>> rtl/core/unique_id_list_stack.sv
// Each item is compared in S_IDLE; S_EXEC updates the list and registers the result,
// holding while the output register is full. A new item is taken only in S_IDLE.
// A waiting result beat sits in the output register while the next item is taken.
// Reset (rst_n low, synchronous) empties the list and clears control state;
// slot contents are not cleared, only slots below the count are ever read.
`default_nettype none
module unique_id_list_stack #(
  parameter int CAPACITY = 64,
  parameter int ID_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire uilst_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output uilst_pkg::out_t     out_data
);
  import uilst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  action_t             act_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  cell_cmd_t           cmd;
  logic [ID_WIDTH-1:0] in_id, cell_id;
  logic [ID_WIDTH-1:0] entry_w [CAPACITY+1];
  logic [CAPACITY-1:0] match_w, occ, tail_sel, top_sel, hit, first, ge;
  logic [ID_WIDTH-1:0] top_id, res_id;
  logic                any_hit, full, empty, can_out, exec_go;
  status_t             stat;
  logic [31:0]         res_wide, cnt_wide;

  assign in_id   = ID_WIDTH'(in_data.node_id);
  assign cell_id = (state_r == S_IDLE) ? in_id : id_r;
  assign entry_w[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]      = (CW'(i) < count_r);
    assign tail_sel[i] = (count_r == CW'(i));
    assign top_sel[i]  = (count_r == CW'(i + 1));

    uilst_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .sel_tail    (tail_sel[i]),
      .sel_shift   (ge[i]),
      .id          (cell_id),
      .right_entry (entry_w[i+1]),
      .entry       (entry_w[i]),
      .match       (match_w[i])
    );
  end

  // First hit and every slot at or above it.
  assign hit     = match_w & occ;
  assign any_hit = |hit;
  assign first   = hit & (~hit + CAPACITY'(1));
  assign ge      = ~(first - CAPACITY'(1));

  always_comb begin
    top_id = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      top_id = top_id | (entry_w[i] & {ID_WIDTH{top_sel[i]}});
    end
  end

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign can_out = !out_valid_r || out_ready;
  assign exec_go = (state_r == S_EXEC) && can_out;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    res_id        = '0;
    stat          = STAT_DONE;
    res_wide      = '0;
    cnt_wide      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.compare = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r)
          ACT_PUSH: begin
            if (full) begin
              stat = STAT_FULL;
            end else begin
              cmd.append = 1'b1;
              count_nxt  = count_r + CW'(1);
            end
          end
          ACT_POP: begin
            if (empty) begin
              stat = STAT_EMPTY;
            end else begin
              res_id    = top_id;
              count_nxt = count_r - CW'(1);
            end
          end
          ACT_REMOVE: begin
            if (empty) begin
              stat = STAT_EMPTY;
            end else if (!any_hit) begin
              stat = STAT_NOT_FOUND;
            end else begin
              // The hit slot holds the id itself; close the gap above it.
              res_id    = id_r;
              cmd.shift = 1'b1;
              count_nxt = count_r - CW'(1);
            end
          end
          ACT_ADD: begin
            if (any_hit) begin
              stat = STAT_PRESENT;
            end else if (full) begin
              stat = STAT_FULL;
            end else begin
              cmd.append = 1'b1;
              count_nxt  = count_r + CW'(1);
            end
          end
          default: stat = STAT_DONE;
        endcase
        if (!can_out) begin
          // Hold until the output register frees up.
          cmd       = '0;
          count_nxt = count_r;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        res_wide                 = 32'(res_id);
        cnt_wide                 = 32'(count_nxt);
        out_data_nxt.result_id   = res_wide[15:0];
        out_data_nxt.status      = stat;
        out_data_nxt.entry_count = cnt_wide[6:0];
        if (!can_out) begin
          out_data_nxt = out_data_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_data.action;
      id_r  <= in_id;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count beyond capacity");

  a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && (act_r == ACT_POP) && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not drop the count");

  a_out_from_exec : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result beat without an update cycle");
`endif

endmodule
`default_nettype wire
